>>> sv/hrst_pkg.sv
// Shared types, constants and codes for the hash ring successor table.
package hrst_pkg;

  // Table geometry
  localparam int unsigned TABLE_POINTS        = 64;
  localparam int unsigned REPLICAS_PER_SERVER = 3;
  localparam int unsigned IDX_W               = $clog2(TABLE_POINTS);
  localparam logic [4:0]  REP_LIMIT           = 5'(REPLICAS_PER_SERVER);

  // Operation codes
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key_hash;
    logic [15:0] srv_id;
    logic [3:0]  replica_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] owner_srv_id;
    logic [3:0]  owner_replica;
  } out_item_t;

  // Field order gives ring order when compared as one unsigned vector
  typedef struct packed {
    logic [31:0] hash;
    logic [15:0] server;
    logic [3:0]  replica;
  } point_t;

  localparam int unsigned POINT_W = $bits(point_t);

  // Write port of the valid-bit array
  typedef struct packed {
    logic             wr;
    logic             val;
    logic [IDX_W-1:0] idx;
  } vld_ctl_t;

endpackage

>>> sv/hrst_ram.sv
// Generic single-port-write, registered-read RAM.
module hrst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/hrst_valid.sv
// Per-point valid bits, cleared at reset, one write port and one read port.
module hrst_valid (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hrst_pkg::vld_ctl_t        ctl_i,
  input  logic [hrst_pkg::IDX_W-1:0] rd_idx_i,
  output logic                      rd_bit_o
);

  logic [hrst_pkg::TABLE_POINTS-1:0] valid_q;

  // Set or clear one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.wr) begin
      valid_q[ctl_i.idx] <= ctl_i.val;
    end
  end

  assign rd_bit_o = valid_q[rd_idx_i];

  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.wr |=> valid_q[$past(ctl_i.idx)] == $past(ctl_i.val))
    else $error("valid bit write did not take effect");

endmodule

>>> sv/hrst_engine.sv
// Scan sequencer: walks the point table for lookup, add and remove transactions.
module hrst_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  hrst_pkg::in_item_t         in_item_i,
  output logic                       in_stall_o,
  input  logic                       vbit_i,
  output logic [hrst_pkg::IDX_W-1:0] vrd_idx_o,
  output hrst_pkg::vld_ctl_t         vld_ctl_o,
  output logic                       ram_we_o,
  output logic [hrst_pkg::IDX_W-1:0] ram_waddr_o,
  output hrst_pkg::point_t           ram_wdata_o,
  output logic [hrst_pkg::IDX_W-1:0] ram_raddr_o,
  input  hrst_pkg::point_t           ram_rdata_i,
  output logic                       res_valid_o,
  output hrst_pkg::out_item_t        res_o,
  input  logic                       res_take_i
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    LAST,
    FINAL,
    DONE
  } state_e;

  state_e                      state_q;
  logic [1:0]                  op_q;
  logic [31:0]                 key_q;
  logic [15:0]                 sid_q;
  logic [3:0]                  rep_q;
  logic [hrst_pkg::IDX_W-1:0]  idx_q;
  logic [1:0]                  stat_q;
  // read pipeline stage, aligned with RAM data
  logic                        p_vld_q;
  logic                        p_valid_q;
  logic [hrst_pkg::IDX_W-1:0]  p_idx_q;
  // accumulators
  logic                        any_q;
  logic                        succ_found_q;
  logic                        hit_q;
  hrst_pkg::point_t            min_q;
  hrst_pkg::point_t            succ_q;
  hrst_pkg::out_item_t         res_q;

  logic    accept;
  logic    last_idx;
  logic    scan_rd;
  logic    add_here;
  logic    live;
  logic    rm_match;
  logic    min_upd;
  logic    succ_upd;
  hrst_pkg::point_t best;

  assign accept   = in_valid_i && (state_q == IDLE);
  assign last_idx = (idx_q == hrst_pkg::IDX_W'(hrst_pkg::TABLE_POINTS - 1));
  assign scan_rd  = (state_q == SCAN) &&
                    ((op_q == hrst_pkg::FUNC_LOOKUP) || (op_q == hrst_pkg::FUNC_REMOVE));
  assign add_here = (state_q == SCAN) && (op_q == hrst_pkg::FUNC_ADD) && !vbit_i;

  // Evaluate the entry returned by the RAM
  assign live     = p_vld_q && p_valid_q;
  assign rm_match = live && (op_q == hrst_pkg::FUNC_REMOVE) && (ram_rdata_i.server == sid_q);
  assign min_upd  = live && (op_q == hrst_pkg::FUNC_LOOKUP) && (!any_q || (ram_rdata_i < min_q));
  assign succ_upd = live && (op_q == hrst_pkg::FUNC_LOOKUP) && (ram_rdata_i.hash > key_q) &&
                    (!succ_found_q || (ram_rdata_i < succ_q));
  assign best     = succ_found_q ? succ_q : min_q;

  // Memory and valid-bit access
  assign vrd_idx_o   = idx_q;
  assign ram_raddr_o = idx_q;
  assign ram_we_o    = add_here;
  assign ram_waddr_o = idx_q;
  assign ram_wdata_o = '{hash: key_q, server: sid_q, replica: rep_q};

  always_comb begin
    vld_ctl_o = '{wr: 1'b0, val: 1'b0, idx: idx_q};
    if (add_here) begin
      vld_ctl_o = '{wr: 1'b1, val: 1'b1, idx: idx_q};
    end else if (rm_match) begin
      vld_ctl_o = '{wr: 1'b1, val: 1'b0, idx: p_idx_q};
    end
  end

  assign in_stall_o  = (state_q != IDLE);
  assign res_valid_o = (state_q == DONE);
  assign res_o       = res_q;

  // Sequencer, pipeline and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      p_vld_q      <= 1'b0;
      any_q        <= 1'b0;
      succ_found_q <= 1'b0;
      hit_q        <= 1'b0;
      idx_q        <= '0;
    end else begin
      p_vld_q   <= scan_rd;
      p_valid_q <= vbit_i;
      p_idx_q   <= idx_q;

      if (min_upd) begin
        min_q <= ram_rdata_i;
      end
      if (live && (op_q == hrst_pkg::FUNC_LOOKUP)) begin
        any_q <= 1'b1;
      end
      if (succ_upd) begin
        succ_q       <= ram_rdata_i;
        succ_found_q <= 1'b1;
      end
      if (rm_match) begin
        hit_q <= 1'b1;
      end

      unique case (state_q)
        IDLE: begin
          if (accept) begin
            op_q         <= in_item_i.func;
            key_q        <= in_item_i.key_hash;
            sid_q        <= in_item_i.srv_id;
            rep_q        <= in_item_i.replica_number;
            idx_q        <= '0;
            stat_q       <= hrst_pkg::ST_OK;
            any_q        <= 1'b0;
            succ_found_q <= 1'b0;
            hit_q        <= 1'b0;
            priority if (in_item_i.func == hrst_pkg::FUNC_LOOKUP ||
                         in_item_i.func == hrst_pkg::FUNC_REMOVE) begin
              state_q <= SCAN;
            end else if (in_item_i.func == hrst_pkg::FUNC_ADD &&
                         {1'b0, in_item_i.replica_number} < hrst_pkg::REP_LIMIT) begin
              state_q <= SCAN;
            end else begin
              state_q <= FINAL;
            end
          end
        end
        SCAN: begin
          idx_q <= idx_q + 1'b1;
          if (op_q == hrst_pkg::FUNC_ADD) begin
            if (!vbit_i) begin
              state_q <= FINAL;
            end else if (last_idx) begin
              stat_q  <= hrst_pkg::ST_FULL;
              state_q <= FINAL;
            end
          end else if (last_idx) begin
            state_q <= LAST;
          end
        end
        LAST: begin
          state_q <= FINAL;
        end
        FINAL: begin
          priority if (op_q == hrst_pkg::FUNC_LOOKUP && any_q) begin
            res_q <= '{status: hrst_pkg::ST_OK, owner_srv_id: best.server,
                       owner_replica: best.replica};
          end else if (op_q == hrst_pkg::FUNC_LOOKUP) begin
            res_q <= '{status: hrst_pkg::ST_EMPTY, owner_srv_id: '0, owner_replica: '0};
          end else if (op_q == hrst_pkg::FUNC_REMOVE) begin
            res_q <= '{status: hit_q ? hrst_pkg::ST_OK : hrst_pkg::ST_NOT_FOUND,
                       owner_srv_id: '0, owner_replica: '0};
          end else begin
            res_q <= '{status: stat_q, owner_srv_id: '0, owner_replica: '0};
          end
          state_q <= DONE;
        end
        DONE: begin
          if (res_take_i) begin
            state_q <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  a_pipe_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> ($past(state_q) == SCAN))
    else $error("read pipeline active outside a scan");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_ctl_o.wr |-> (state_q == SCAN || state_q == LAST))
    else $error("table written outside a scan");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_take_i |=> res_valid_o && $stable(res_o))
    else $error("pending result lost or changed");

endmodule

>>> sv/hash_ring_successor_table_core.sv
// Top level of the consistent-hashing ring directory with its output register.
// Lookup and remove scan every table point before the result reaches the output
// register; add stops at the first free point; ignored items skip the scan.
// One transaction in flight; the next is accepted after the result moves to the
// output register. The scan reads one point per cycle through one RAM port.
// Reset clears all valid bits at once: the table starts empty, no clearing pass.
module hash_ring_successor_table_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hrst_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hrst_pkg::out_item_t out_item_o
);

  logic                       vbit;
  logic [hrst_pkg::IDX_W-1:0] vrd_idx;
  hrst_pkg::vld_ctl_t         vld_ctl;
  logic                       ram_we;
  logic [hrst_pkg::IDX_W-1:0] ram_waddr;
  logic [hrst_pkg::IDX_W-1:0] ram_raddr;
  hrst_pkg::point_t           ram_wdata;
  hrst_pkg::point_t           ram_rdata;
  logic                       res_valid;
  logic                       res_take;
  hrst_pkg::out_item_t        res;
  logic                       out_valid_q;
  hrst_pkg::out_item_t        out_item_q;

  hrst_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .vbit_i      (vbit),
    .vrd_idx_o   (vrd_idx),
    .vld_ctl_o   (vld_ctl),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  hrst_valid u_valid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (vld_ctl),
    .rd_idx_i (vrd_idx),
    .rd_bit_o (vbit)
  );

  hrst_ram #(
    .WIDTH (hrst_pkg::POINT_W),
    .DEPTH (hrst_pkg::TABLE_POINTS)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Move the result into the output register when it is free or draining
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload until the next result is taken
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_owner_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != hrst_pkg::ST_OK) |->
      (out_item_o.owner_srv_id == '0) && (out_item_o.owner_replica == '0))
    else $error("owner fields set on a failed transaction");

endmodule
